>>> rtl/beh_pkg.sv
`timescale 1ns / 1ps

// Shared types, constants and helpers of the binned event histogrammer.
package beh_pkg;

	// Histogram geometry and count width.
	localparam int MAX_CENT_CLASSES = 8;
	localparam int MAX_VERTEX_EDGES = 8;
	localparam int COUNT_WIDTH      = 32;

	// Field widths of the item channels.
	localparam int CENT_W    = 8;
	localparam int VTX_W     = 16;
	localparam int WEIGHT_W  = 16;
	localparam int CLS_W     = 3;
	localparam int BIN_W     = 3;
	localparam int OUT_CNT_W = 32;

	// Bin memory: entry {class, bin}, a row of eight entries per class.
	localparam int ADDR_W    = CLS_W + BIN_W;
	localparam int BIN_DEPTH = 2 ** ADDR_W;

	// Configuration port.
	localparam int NUM_W     = 4;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENT_EDGES = 3'd0,
		CFG_NUM_CENT   = 3'd1,
		CFG_VTX_LO     = 3'd2,
		CFG_VTX_HI     = 3'd3,
		CFG_NUM_VTX    = 3'd4
	} cfg_idx_t;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// Lookup outcome of one item, handed from the search to the update logic.
	typedef struct packed {
		logic                kind;
		logic                class_hit;
		logic                in_hist;
		logic [CLS_W-1:0]    cls;
		logic [BIN_W-1:0]    vbin;
		logic [WEIGHT_W-1:0] weight;
	} look_t;

	// Add a weight to a count, sticking at the largest count.
	function automatic count_t sat_add(count_t a, logic [WEIGHT_W-1:0] w);
		logic [COUNT_WIDTH:0] sum;
		sum = {1'b0, a} + {{(COUNT_WIDTH + 1 - WEIGHT_W){1'b0}}, w};
		sat_add = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
	endfunction

endpackage

>>> rtl/beh_in_if.sv
`timescale 1ns / 1ps

// Event item channel.
interface beh_in_if;
	logic                               valid;
	logic                               ready;
	logic                               kind;
	logic [beh_pkg::CENT_W-1:0]         centrality;
	logic signed [beh_pkg::VTX_W-1:0]   zvertex;
	logic [beh_pkg::WEIGHT_W-1:0]       weight;

	modport source(output valid, kind, centrality, zvertex, weight, input ready);
	modport sink(input valid, kind, centrality, zvertex, weight, output ready);
endinterface

>>> rtl/beh_out_if.sv
`timescale 1ns / 1ps

// Result item channel.
interface beh_out_if;
	logic                              valid;
	logic                              ready;
	logic                              inside_res;
	logic [beh_pkg::CLS_W-1:0]         cent_class;
	logic [beh_pkg::BIN_W-1:0]         vertex_bin;
	logic [beh_pkg::WEIGHT_W-1:0]      added;
	logic [beh_pkg::OUT_CNT_W-1:0]     bin_count;
	logic [beh_pkg::OUT_CNT_W-1:0]     class_count;
	logic [beh_pkg::OUT_CNT_W-1:0]     total_count;

	modport source(output valid, inside_res, cent_class, vertex_bin, added, bin_count,
		class_count, total_count, input ready);
	modport sink(input valid, inside_res, cent_class, vertex_bin, added, bin_count,
		class_count, total_count, output ready);
endinterface

>>> rtl/beh_bin_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module beh_bin_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/beh_lookup.sv
`timescale 1ns / 1ps

// Edge registers and the class and vertex bin search of an incoming item.
module beh_lookup (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [beh_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [beh_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                kind,
	input  logic [beh_pkg::CENT_W-1:0]          centrality,
	input  logic signed [beh_pkg::VTX_W-1:0]    zvertex,
	input  logic [beh_pkg::WEIGHT_W-1:0]        weight,
	output beh_pkg::look_t                      look
);

	localparam int VTX_ALL_W = beh_pkg::MAX_VERTEX_EDGES * beh_pkg::VTX_W;

	logic [beh_pkg::CFG_W-1:0] cent_edges_q;
	logic [beh_pkg::NUM_W-1:0] num_cent_q;
	logic [beh_pkg::CFG_W-1:0] vtx_lo_q;
	logic [beh_pkg::CFG_W-1:0] vtx_hi_q;
	logic [beh_pkg::NUM_W-1:0] num_vtx_q;

	logic [beh_pkg::NUM_W-1:0]         n_cent;
	logic [beh_pkg::NUM_W-1:0]         n_vtx;
	logic [VTX_ALL_W-1:0]              vtx_all;
	logic signed [beh_pkg::VTX_W-1:0]  vedge [beh_pkg::MAX_VERTEX_EDGES];
	logic [beh_pkg::MAX_CENT_CLASSES-1:0]   cls_hit;
	logic [beh_pkg::MAX_VERTEX_EDGES-2:0]   bin_hit;
	logic [beh_pkg::CLS_W-1:0]         cls;
	logic [beh_pkg::BIN_W-1:0]         vbin;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cent_edges_q <= '0;
			num_cent_q   <= '0;
			vtx_lo_q     <= '0;
			vtx_hi_q     <= '0;
			num_vtx_q    <= '0;
		end else if (cfg_we) begin
			unique case (beh_pkg::cfg_idx_t'(cfg_index))
				beh_pkg::CFG_CENT_EDGES: cent_edges_q <= cfg_wdata;
				beh_pkg::CFG_NUM_CENT:   num_cent_q   <= cfg_wdata[beh_pkg::NUM_W-1:0];
				beh_pkg::CFG_VTX_LO:     vtx_lo_q     <= cfg_wdata;
				beh_pkg::CFG_VTX_HI:     vtx_hi_q     <= cfg_wdata;
				beh_pkg::CFG_NUM_VTX:    num_vtx_q    <= cfg_wdata[beh_pkg::NUM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Edge counts beyond the table size act as a full table.
	assign n_cent = (num_cent_q > beh_pkg::NUM_W'(beh_pkg::MAX_CENT_CLASSES)) ?
		beh_pkg::NUM_W'(beh_pkg::MAX_CENT_CLASSES) : num_cent_q;
	assign n_vtx = (num_vtx_q > beh_pkg::NUM_W'(beh_pkg::MAX_VERTEX_EDGES)) ?
		beh_pkg::NUM_W'(beh_pkg::MAX_VERTEX_EDGES) : num_vtx_q;
	assign vtx_all = {vtx_hi_q, vtx_lo_q};

	// Per-edge compares, all in parallel.
	always_comb begin
		for (int i = 0; i < beh_pkg::MAX_VERTEX_EDGES; i++) begin
			vedge[i] = signed'(vtx_all[beh_pkg::VTX_W*i +: beh_pkg::VTX_W]);
		end
		for (int i = 0; i < beh_pkg::MAX_CENT_CLASSES; i++) begin
			cls_hit[i] = (beh_pkg::NUM_W'(i) < n_cent) &&
				(centrality < cent_edges_q[beh_pkg::CENT_W*i +: beh_pkg::CENT_W]);
		end
		for (int i = 0; i < beh_pkg::MAX_VERTEX_EDGES - 1; i++) begin
			bin_hit[i] = (beh_pkg::NUM_W'(i + 1) < n_vtx) &&
				(zvertex >= vedge[i]) && (zvertex < vedge[i + 1]);
		end
	end

	// First match wins in both searches.
	always_comb begin
		cls  = '0;
		vbin = '0;
		for (int i = beh_pkg::MAX_CENT_CLASSES - 1; i >= 0; i--) begin
			if (cls_hit[i]) begin
				cls = beh_pkg::CLS_W'(i);
			end
		end
		for (int i = beh_pkg::MAX_VERTEX_EDGES - 2; i >= 0; i--) begin
			if (bin_hit[i]) begin
				vbin = beh_pkg::BIN_W'(i);
			end
		end
	end

	assign look.kind      = kind;
	assign look.class_hit = |cls_hit;
	assign look.in_hist   = (|cls_hit) && (|bin_hit);
	assign look.cls       = cls;
	assign look.vbin      = vbin;
	assign look.weight    = weight;

endmodule

>>> rtl/beh_update.sv
`timescale 1ns / 1ps

// Read-modify-write of the bin memory, row sums, grand total and result register.
module beh_update (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  beh_pkg::look_t                look,
	input  beh_pkg::count_t               rdata,
	output logic                          ram_we,
	output logic [beh_pkg::ADDR_W-1:0]    ram_waddr,
	output beh_pkg::count_t               ram_wdata,
	output logic                          busy,
	beh_out_if.source                     res
);

	beh_pkg::look_t                   look_s1;
	logic                             valid_s1;
	logic [beh_pkg::BIN_DEPTH-1:0]    bin_vld_q;
	beh_pkg::count_t                  class_sums_q [beh_pkg::MAX_CENT_CLASSES];
	beh_pkg::count_t                  total_q;

	logic                             out_valid_q;
	logic                             in_hist_q;
	logic [beh_pkg::CLS_W-1:0]        cls_q;
	logic [beh_pkg::BIN_W-1:0]        vbin_q;
	logic [beh_pkg::WEIGHT_W-1:0]     added_q;
	beh_pkg::count_t                  bin_cnt_q;
	beh_pkg::count_t                  cls_cnt_q;
	beh_pkg::count_t                  tot_cnt_q;

	logic [beh_pkg::ADDR_W-1:0]       addr_s1;
	logic                             complete;
	logic                             add_now;
	beh_pkg::count_t                  old_bin;
	beh_pkg::count_t                  old_cls;
	beh_pkg::count_t                  new_bin;
	beh_pkg::count_t                  new_cls;
	beh_pkg::count_t                  new_tot;

	// Stage 1 holds the item while the memory read returns.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (start) begin
			valid_s1 <= 1'b1;
		end else if (complete) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			look_s1 <= look;
		end
	end

	// An entry never written since the last clear reads as zero.
	assign addr_s1  = {look_s1.cls, look_s1.vbin};
	assign old_bin  = bin_vld_q[addr_s1] ? rdata : '0;
	assign old_cls  = class_sums_q[look_s1.cls];
	assign new_bin  = beh_pkg::sat_add(old_bin, look_s1.weight);
	assign new_cls  = beh_pkg::sat_add(old_cls, look_s1.weight);
	assign new_tot  = beh_pkg::sat_add(total_q, look_s1.weight);

	// The item finishes once the result register can take it.
	assign complete = valid_s1 && (!out_valid_q || res.ready);
	assign add_now  = complete && !look_s1.kind && look_s1.in_hist;
	assign busy     = valid_s1;

	assign ram_we    = add_now;
	assign ram_waddr = addr_s1;
	assign ram_wdata = new_bin;

	// Count state: valid bits, row sums and grand total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
			total_q   <= '0;
			for (int i = 0; i < beh_pkg::MAX_CENT_CLASSES; i++) begin
				class_sums_q[i] <= '0;
			end
		end else if (complete && look_s1.kind) begin
			bin_vld_q <= '0;
			total_q   <= '0;
			for (int i = 0; i < beh_pkg::MAX_CENT_CLASSES; i++) begin
				class_sums_q[i] <= '0;
			end
		end else if (add_now) begin
			bin_vld_q[addr_s1]          <= 1'b1;
			class_sums_q[look_s1.cls]   <= new_cls;
			total_q                     <= new_tot;
		end
	end

	// Result register handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (complete) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; a clear item reports all zeros.
	always_ff @(posedge clk) begin
		if (complete) begin
			if (look_s1.kind) begin
				in_hist_q <= 1'b0;
				cls_q     <= '0;
				vbin_q    <= '0;
				added_q   <= '0;
				bin_cnt_q <= '0;
				cls_cnt_q <= '0;
				tot_cnt_q <= '0;
			end else begin
				in_hist_q <= look_s1.in_hist;
				cls_q     <= look_s1.class_hit ? look_s1.cls : '0;
				vbin_q    <= look_s1.in_hist ? look_s1.vbin : '0;
				added_q   <= look_s1.in_hist ? look_s1.weight : '0;
				bin_cnt_q <= look_s1.in_hist ? new_bin : '0;
				cls_cnt_q <= !look_s1.class_hit ? '0 : (look_s1.in_hist ? new_cls : old_cls);
				tot_cnt_q <= look_s1.in_hist ? new_tot : total_q;
			end
		end
	end

	assign res.valid       = out_valid_q;
	assign res.inside_res  = in_hist_q;
	assign res.cent_class  = cls_q;
	assign res.vertex_bin  = vbin_q;
	assign res.added       = added_q;
	assign res.bin_count   = bin_cnt_q[beh_pkg::OUT_CNT_W-1:0];
	assign res.class_count = cls_cnt_q[beh_pkg::OUT_CNT_W-1:0];
	assign res.total_count = tot_cnt_q[beh_pkg::OUT_CNT_W-1:0];

endmodule

>>> rtl/binned_event_histogrammer.sv
`timescale 1ns / 1ps

// Two-dimensional event histogram over centrality class and vertex bin with
// programmable edges. Each event item yields one result item; a clear item
// zeroes every count at once and also yields one (all-zero) result. One item
// is in work at a time: it is accepted and its bin is read from the 64-entry
// bin memory while the item moves into the update stage; once the output
// register can take the result, the count, row sum and grand total are
// updated and the result is loaded into the output register. The block
// takes no new item before the read-modify-write of the bin memory for the
// last one is through. While a result waits unclaimed, the item behind it
// stays in the update stage and input is held off. The output register lets
// the next item be accepted while a result still waits. Per-entry valid bits
// stand in for clearing the bin memory, so there is no clearing pass after
// reset or after a clear item. The user is to write edge registers through
// the cfg port only while the block is idle; the block does not enforce it.
module binned_event_histogrammer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [beh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [beh_pkg::CFG_W-1:0]     cfg_wdata,
	beh_in_if.sink                        evt,
	beh_out_if.source                     res
);

	beh_pkg::look_t                   look;
	logic                             accept;
	logic                             busy;
	logic                             ram_we;
	logic [beh_pkg::ADDR_W-1:0]       ram_waddr;
	beh_pkg::count_t                  ram_wdata;
	beh_pkg::count_t                  ram_rdata;

	// Input handshake.
	assign evt.ready = !busy;
	assign accept    = evt.valid && !busy;

	beh_lookup u_lookup (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.kind       (evt.kind),
		.centrality (evt.centrality),
		.zvertex    (evt.zvertex),
		.weight     (evt.weight),
		.look       (look)
	);

	beh_bin_ram #(
		.WIDTH (beh_pkg::COUNT_WIDTH),
		.DEPTH (beh_pkg::BIN_DEPTH)
	) u_bin_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr ({look.cls, look.vbin}),
		.rdata (ram_rdata)
	);

	beh_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.look      (look),
		.rdata     (ram_rdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.busy      (busy),
		.res       (res)
	);

endmodule

>>> rtl/beh_checker.sv
`timescale 1ns / 1ps

// Port-level checks of the histogrammer.
module beh_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              evt_valid,
	input logic                              evt_ready,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic                              res_inside,
	input logic [beh_pkg::BIN_W-1:0]         res_vbin,
	input logic [beh_pkg::WEIGHT_W-1:0]      res_added,
	input logic [beh_pkg::OUT_CNT_W-1:0]     res_bin_count,
	input logic [beh_pkg::OUT_CNT_W-1:0]     res_class_count,
	input logic [beh_pkg::OUT_CNT_W-1:0]     res_total_count
);

	// Only one item is in work: the cycle after an accept takes nothing.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready |=> !evt_ready)
		else $error("item accepted while another is in work");

	// A stalled result holds its bin and total counts.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_bin_count) &&
			$stable(res_total_count))
		else $error("stalled result changed");

	// An event outside the histogram adds nothing and addresses no bin.
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_inside |-> res_added == '0 && res_bin_count == '0 &&
			res_vbin == '0)
		else $error("outside event reports a bin");

	// A bin never exceeds its row sum, nor a row sum the grand total.
	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_inside |-> res_bin_count <= res_class_count &&
			res_class_count <= res_total_count)
		else $error("count ordering broken");

endmodule

bind binned_event_histogrammer beh_checker u_beh_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.evt_valid       (evt.valid),
	.evt_ready       (evt.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_inside      (res.inside_res),
	.res_vbin        (res.vertex_bin),
	.res_added       (res.added),
	.res_bin_count   (res.bin_count),
	.res_class_count (res.class_count),
	.res_total_count (res.total_count)
);

>>> bench/tb_binned_event_histogrammer.sv
`timescale 1ns / 1ps

module tb_binned_event_histogrammer;

	localparam logic KIND_EVENT    = 1'b0;
	localparam logic KIND_CLEAR    = 1'b1;
	localparam int   GAP_MAX       = 19;
	localparam int   LONG_HOLD     = 200;
	localparam int   STALL_LIMIT   = 4000;
	localparam int   RANDOM_ITEMS  = 1250;
	localparam int   SETTLE_CYCLES = 6;

	localparam int CENT_W    = beh_pkg::CENT_W;
	localparam int VTX_W     = beh_pkg::VTX_W;
	localparam int WEIGHT_W  = beh_pkg::WEIGHT_W;
	localparam int CLS_W     = beh_pkg::CLS_W;
	localparam int BIN_W     = beh_pkg::BIN_W;
	localparam int OUT_CNT_W = beh_pkg::OUT_CNT_W;
	localparam int CFG_W     = beh_pkg::CFG_W;
	localparam int NUM_W     = beh_pkg::NUM_W;

	// One event item as offered to the block.
	typedef struct packed {
		logic                    kind;
		logic [CENT_W-1:0]       cent;
		logic signed [VTX_W-1:0] z;
		logic [WEIGHT_W-1:0]     weight;
	} hit_t;

	// One result item as delivered by the block.
	typedef struct packed {
		logic                 in_hist;
		logic [CLS_W-1:0]     cls;
		logic [BIN_W-1:0]     vbin;
		logic [WEIGHT_W-1:0]  added;
		logic [OUT_CNT_W-1:0] bin_cnt;
		logic [OUT_CNT_W-1:0] row_cnt;
		logic [OUT_CNT_W-1:0] total;
	} tally_t;

	// Keeps its own copy of the edges and counts, predicts each result and
	// compares the delivered results in order.
	class histo_scoreboard;
		logic [CFG_W-1:0] cls_edges;
		logic [CFG_W-1:0] z_lo;
		logic [CFG_W-1:0] z_hi;
		logic [NUM_W-1:0] cls_used;
		logic [NUM_W-1:0] z_used;
		beh_pkg::count_t  cells[beh_pkg::BIN_DEPTH];
		beh_pkg::count_t  row_sums[beh_pkg::MAX_CENT_CLASSES];
		beh_pkg::count_t  grand;
		tally_t           due_results[$];
		int               errors;

		function new();
			cls_edges = '0;
			z_lo = '0;
			z_hi = '0;
			cls_used = '0;
			z_used = '0;
			errors = 0;
			zero_counts();
		endfunction

		function void zero_counts();
			foreach (cells[i])
				cells[i] = '0;
			foreach (row_sums[i])
				row_sums[i] = '0;
			grand = '0;
		endfunction

		function void set_reg(beh_pkg::cfg_idx_t idx, logic [CFG_W-1:0] d);
			case (idx)
				beh_pkg::CFG_CENT_EDGES: cls_edges = d;
				beh_pkg::CFG_NUM_CENT:   cls_used = d[NUM_W-1:0];
				beh_pkg::CFG_VTX_LO:     z_lo = d;
				beh_pkg::CFG_VTX_HI:     z_hi = d;
				beh_pkg::CFG_NUM_VTX:    z_used = d[NUM_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [CENT_W-1:0] cls_edge(int i);
			return cls_edges[CENT_W*i +: CENT_W];
		endfunction

		function logic signed [VTX_W-1:0] z_edge(int i);
			if (i < 4)
				return z_lo[VTX_W*i +: VTX_W];
			return z_hi[VTX_W*(i-4) +: VTX_W];
		endfunction

		// The count sticks at its largest value instead of wrapping.
		function beh_pkg::count_t clamp_add(beh_pkg::count_t a, logic [WEIGHT_W-1:0] w);
			logic [beh_pkg::COUNT_WIDTH:0] s;
			s = {1'b0, a} + (beh_pkg::COUNT_WIDTH + 1)'(w);
			return s[beh_pkg::COUNT_WIDTH] ? '1 : s[beh_pkg::COUNT_WIDTH-1:0];
		endfunction

		// Works out the result of one accepted item and updates the counts.
		function void log_event(hit_t h);
			tally_t                  t;
			logic signed [VTX_W-1:0] zv;
			int                      n, c, v, i, idx;
			t = '0;
			zv = h.z;
			if (h.kind == KIND_CLEAR) begin
				zero_counts();
				due_results.push_back(t);
				return;
			end
			// The class is the first edge strictly above the value.
			n = (cls_used > beh_pkg::MAX_CENT_CLASSES) ? beh_pkg::MAX_CENT_CLASSES
				: int'(cls_used);
			c = -1;
			for (i = 0; i < n; i++)
				if (c < 0 && h.cent < cls_edge(i))
					c = i;
			// The bin is the first edge pair that holds the position.
			v = -1;
			if (c >= 0) begin
				n = (z_used > beh_pkg::MAX_VERTEX_EDGES) ? beh_pkg::MAX_VERTEX_EDGES
					: int'(z_used);
				for (i = 0; i + 1 < n; i++)
					if (v < 0 && zv >= z_edge(i) && zv < z_edge(i + 1))
						v = i;
			end
			if (v >= 0) begin
				idx = c * (2 ** BIN_W) + v;
				cells[idx] = clamp_add(cells[idx], h.weight);
				row_sums[c] = clamp_add(row_sums[c], h.weight);
				grand = clamp_add(grand, h.weight);
				t.in_hist = 1'b1;
				t.vbin = BIN_W'(v);
				t.added = h.weight;
				t.bin_cnt = OUT_CNT_W'(cells[idx]);
			end
			if (c >= 0) begin
				t.cls = CLS_W'(c);
				t.row_cnt = OUT_CNT_W'(row_sums[c]);
			end
			t.total = OUT_CNT_W'(grand);
			due_results.push_back(t);
		endfunction

		function void flag(string name, logic [63:0] want, logic [63:0] got);
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		endfunction

		function void match_result(tally_t got);
			tally_t want;
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: result item with nothing expected: %h", $time, got);
				return;
			end
			want = due_results.pop_front();
			if (got.in_hist !== want.in_hist)
				flag("inside_res", 64'(want.in_hist), 64'(got.in_hist));
			if (got.cls !== want.cls)
				flag("cent_class", 64'(want.cls), 64'(got.cls));
			if (got.vbin !== want.vbin)
				flag("vertex_bin", 64'(want.vbin), 64'(got.vbin));
			if (got.added !== want.added)
				flag("added", 64'(want.added), 64'(got.added));
			if (got.bin_cnt !== want.bin_cnt)
				flag("bin_count", 64'(want.bin_cnt), 64'(got.bin_cnt));
			if (got.row_cnt !== want.row_cnt)
				flag("class_count", 64'(want.row_cnt), 64'(got.row_cnt));
			if (got.total !== want.total)
				flag("total_count", 64'(want.total), 64'(got.total));
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [beh_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]              cfg_wdata;

	beh_in_if  evt_ch();
	beh_out_if res_ch();

	histo_scoreboard board = new();
	bit              no_idle;
	bit              hold_req;
	int              idle_cycles;

	binned_event_histogrammer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.evt       (evt_ch),
		.res       (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Log accepted items on both channels and watch for a stuck block.
	always @(posedge clk) begin
		tally_t got;
		hit_t   seen;
		bit     moved;
		if (arst_n === 1'b1) begin
			moved = 1'b0;
			if (res_ch.valid && res_ch.ready) begin
				got = {res_ch.inside_res, res_ch.cent_class, res_ch.vertex_bin,
					res_ch.added, res_ch.bin_count, res_ch.class_count, res_ch.total_count};
				board.match_result(got);
				moved = 1'b1;
			end
			if (evt_ch.valid && evt_ch.ready) begin
				seen = {evt_ch.kind, evt_ch.centrality, evt_ch.zvertex, evt_ch.weight};
				board.log_event(seen);
				moved = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, idle_cycles);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		return no_idle ? 0 : int'($urandom_range(0, GAP_MAX));
	endfunction

	// Result side: stalls a random number of cycles before each item, and
	// once holds off for a long stretch so that the block backs up.
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = pick_gap();
			if (hold_req) begin
				hold_req = 1'b0;
				stall = LONG_HOLD;
			end
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
		end
	end

	// Offer one item after a random gap and hold it until it is taken.
	task automatic send_item(hit_t h);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.kind <= h.kind;
		evt_ch.centrality <= h.cent;
		evt_ch.zvertex <= h.z;
		evt_ch.weight <= h.weight;
		do @(posedge clk); while (evt_ch.ready !== 1'b1);
	endtask

	task automatic hit(logic [CENT_W-1:0] cent, logic signed [VTX_W-1:0] z,
		logic [WEIGHT_W-1:0] w);
		send_item({KIND_EVENT, cent, z, w});
	endtask

	// A clear carries random content in its other fields.
	task automatic clear_counts();
		send_item({KIND_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom)});
	endtask

	// Stop offering and wait until every result has come out. The first edge
	// lets the monitor log the item that was taken last.
	task automatic settle();
		evt_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(beh_pkg::cfg_idx_t idx, logic [CFG_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		board.set_reg(idx, d);
	endtask

	task automatic load_edges(logic [CFG_W-1:0] ce, logic [CFG_W-1:0] nc,
		logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi, logic [CFG_W-1:0] nv);
		write_reg(beh_pkg::CFG_CENT_EDGES, ce);
		write_reg(beh_pkg::CFG_NUM_CENT, nc);
		write_reg(beh_pkg::CFG_VTX_LO, lo);
		write_reg(beh_pkg::CFG_VTX_HI, hi);
		write_reg(beh_pkg::CFG_NUM_VTX, nv);
		cfg_we <= 1'b0;
	endtask

	// Mostly ascending edges at a random scale, sometimes arbitrary ones, and
	// edge counts that now and then exceed the maximum or carry upper bits.
	task automatic random_config();
		logic [CFG_W-1:0]     ce, nc, nv;
		logic [2*CFG_W-1:0]   zall;
		int                   v, scale, i;
		if ($urandom_range(0, 5) == 0) begin
			ce = {$urandom, $urandom};
		end else begin
			v = $urandom_range(0, 80);
			for (i = 0; i < 8; i++) begin
				ce[CENT_W*i +: CENT_W] = CENT_W'(v);
				v = v + int'($urandom_range(0, 40));
				if (v > 255)
					v = 255;
			end
		end
		if ($urandom_range(0, 5) == 0) begin
			zall = {$urandom, $urandom, $urandom, $urandom};
		end else begin
			case ($urandom_range(0, 2))
				0: scale = 40;
				1: scale = 1500;
				default: scale = 9000;
			endcase
			v = int'($urandom_range(0, 8 * scale)) - 4 * scale;
			if ($urandom_range(0, 7) == 0)
				v = -32768;
			for (i = 0; i < 8; i++) begin
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				zall[VTX_W*i +: VTX_W] = v[VTX_W-1:0];
				v = v + int'($urandom_range(1, scale));
			end
		end
		nc = '0;
		nv = '0;
		if ($urandom_range(0, 3) == 0)
			nc = {$urandom, $urandom};
		if ($urandom_range(0, 3) == 0)
			nv = {$urandom, $urandom};
		nc[NUM_W-1:0] = ($urandom_range(0, 7) == 0) ? NUM_W'($urandom_range(0, 15))
			: NUM_W'($urandom_range(1, 8));
		nv[NUM_W-1:0] = ($urandom_range(0, 7) == 0) ? NUM_W'($urandom_range(0, 15))
			: NUM_W'($urandom_range(2, 8));
		load_edges(ce, nc, zall[CFG_W-1:0], zall[2*CFG_W-1:CFG_W], nv);
	endtask

	// Values are drawn near the current edges most of the time so that the
	// class and bin boundaries are hit from both sides.
	function automatic hit_t random_hit();
		hit_t h;
		int   i;
		h.kind = ($urandom_range(0, 39) == 0) ? KIND_CLEAR : KIND_EVENT;
		i = $urandom_range(0, 7);
		if ($urandom_range(0, 2) == 0)
			h.cent = CENT_W'($urandom);
		else
			h.cent = board.cls_edge(i) + 8'($urandom_range(0, 2)) - 8'd1;
		case ($urandom_range(0, 3))
			0: h.z = VTX_W'($urandom);
			1: h.z = board.z_edge(i) + 16'($urandom_range(0, 2)) - 16'd1;
			default: h.z = board.z_edge(i) + 16'($urandom_range(0, 400));
		endcase
		case ($urandom_range(0, 7))
			0: h.weight = '0;
			1: h.weight = '1;
			2: h.weight = WEIGHT_W'($urandom_range(1, 15));
			default: h.weight = WEIGHT_W'($urandom);
		endcase
		return h;
	endfunction

	initial begin
		int sent, phase, count, k;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= beh_pkg::CFG_CENT_EDGES;
		cfg_wdata <= '0;
		evt_ch.valid <= 1'b0;
		evt_ch.kind <= KIND_EVENT;
		evt_ch.centrality <= '0;
		evt_ch.zvertex <= '0;
		evt_ch.weight <= '0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		idle_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Edges at their reset values: no class is in use, nothing counts.
		hit(8'd0, 16'sd0, 16'd5);
		hit(8'd255, -16'sd1, 16'd1);
		clear_counts();
		settle();

		// Ascending edges with both edge counts above the maximum.
		load_edges({8'd255, 8'd250, 8'd230, 8'd200, 8'd150, 8'd100, 8'd50, 8'd10},
			64'd15,
			{16'h0000, 16'hFFF6, 16'hFC18, 16'h8000},
			{16'h7FFF, 16'h4E20, 16'h03E8, 16'h000A},
			64'd15);
		hit(8'd0, 16'sh8000, 16'hFFFF);
		hit(8'd254, 16'sd32766, 16'd1);
		hit(8'd255, 16'sd0, 16'd7);
		// Class found but the position lies on the top edge.
		hit(8'd100, 16'sd32767, 16'd9);
		// Pure lookup with a zero weight.
		hit(8'd10, -16'sd10, 16'd0);
		hit(8'd9, -16'sd1, 16'd300);
		repeat (3) hit(8'd249, 16'sd20000, 16'hFFFF);
		clear_counts();
		hit(8'd0, 16'sh8000, 16'd1);
		settle();

		// Edges out of order, and a single vertex edge giving no bins.
		load_edges({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd5, 8'd200}, 64'd8,
			{16'h0000, 16'hFFCE, 16'h0064, 16'hFF9C}, 64'd0, 64'd1);
		hit(8'd100, 16'sd0, 16'd4);
		hit(8'd220, 16'sd0, 16'd4);
		settle();
		load_edges({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd5, 8'd200}, 64'd8,
			{16'h0000, 16'hFFCE, 16'h0064, 16'hFF9C}, 64'd0, 64'd3);
		hit(8'd100, 16'sd99, 16'd2);
		hit(8'd100, 16'sd100, 16'd2);
		settle();

		// Extreme edge values.
		load_edges('1, 64'd8, {16'h8000, 16'h8000, 16'h7FFF, 16'h8000},
			{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 64'd8);
		hit(8'd254, 16'sd32767, 16'hFFFF);
		hit(8'd0, 16'sh8000, 16'hFFFF);
		hit(8'd255, 16'sd0, 16'd1);
		hit(8'd128, 16'sd12345, 16'h1234);

		// Random phases, each with its own edge setting. Phase one runs
		// without gaps; in phase two the result side holds off for a long
		// stretch while items keep coming.
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			random_config();
			no_idle = (phase == 1) || ($urandom_range(0, 4) == 0);
			if (phase == 2) begin
				no_idle = 1'b1;
				hold_req = 1'b1;
			end
			count = $urandom_range(60, 140);
			for (k = 0; k < count; k++)
				send_item(random_hit());
			sent += count;
			phase++;
		end
		settle();

		if (board.errors == 0 && board.due_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
